// ===== rtl/pba_pkg.sv =====
// shared types and constants for the packed bitfield array
`timescale 1ns / 1ps
package pba_pkg;

  localparam int STORE_WORDS = 64;
  localparam int WORD_W      = 32;
  localparam int TOTAL_BITS  = STORE_WORDS * WORD_W;
  localparam int WADDR_W     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  localparam int INDEX_W  = 11;
  localparam int EBITS_W  = 5;
  localparam int BITPOS_W = 16;
  localparam int READ_W   = 31;

  localparam int          CFG_ADDR_W    = 3;
  localparam int          CFG_DATA_W    = 32;
  localparam logic [0:0]  REG_ELEM_BITS = 1'b0;
  localparam logic [EBITS_W-1:0] ELEM_BITS_RESET = 5'd8;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [INDEX_W-1:0] index;
    logic [31:0]        write_value;
  } in_t;

  typedef struct packed {
    logic [READ_W-1:0] read_value;
    logic              truncated;
    logic              out_of_range;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_WR_HI,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic merge;
    logic wr_hi;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic wr_hi_needed;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/pba_ctrl.sv =====
// sequencer for the packed bitfield array
`timescale 1ns / 1ps
module pba_ctrl import pba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ:  state_nxt = ST_MERGE;
      ST_MERGE: state_nxt = sts.wr_hi_needed ? ST_WR_HI : ST_PUSH;
      ST_WR_HI: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_READ:  cmd.rd_issue = 1'b1;
      ST_MERGE: cmd.merge    = 1'b1;
      ST_WR_HI: cmd.wr_hi    = 1'b1;
      ST_PUSH:  cmd.push     = sts.out_free;
      default:  cmd          = '0;
    endcase
  end

endmodule

// ===== rtl/pba_dp.sv =====
// word store, bit window merge and result register
`timescale 1ns / 1ps
module pba_dp import pba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [EBITS_W-1:0] elem_bits,
  input  in_t                in_data,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_stall,
  output logic               out_valid,
  output out_t               out_data
);

  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] vld_r;

  logic                op_r;
  logic [31:0]         val_r;
  logic [EBITS_W-1:0]  w_r;
  logic [BITPOS_W-1:0] bitpos_r;

  logic [WORD_W-1:0] rd_lo_r, rd_hi_r;
  logic              vld_lo_r, vld_hi_r;

  logic [READ_W-1:0] res_rd_r;
  logic              res_tr_r, res_oor_r;
  logic [WORD_W-1:0] new_hi_r;

  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;

  logic [INDEX_W-1:0]  id;
  logic [INDEX_W:0]    id_p1;
  logic [WADDR_W-1:0]  addr_lo, addr_hi;
  logic                hi_ok;
  logic [BITPOS_W:0]   bit_end;
  logic                oor;
  logic [4:0]          off;
  logic [31:0]         emask;
  logic [63:0]         window, win_sh, mask64, ins64, new_win;
  logic                wr_lo;
  logic                we;
  logic [WADDR_W-1:0]  waddr;
  logic [WORD_W-1:0]   wdata;

  // element geometry
  assign id      = bitpos_r[BITPOS_W-1:5];
  assign id_p1   = {1'b0, id} + {{INDEX_W{1'b0}}, 1'b1};
  assign addr_lo = WADDR_W'(id);
  assign addr_hi = WADDR_W'(id_p1);
  assign hi_ok   = 32'(id_p1) < 32'(STORE_WORDS);
  assign off     = bitpos_r[4:0];
  assign bit_end = {1'b0, bitpos_r} + (BITPOS_W + 1)'(w_r);
  assign oor     = 32'(bit_end) > 32'(TOTAL_BITS);
  assign emask   = 32'((33'd1 << w_r) - 33'd1);

  // two-word window, missing or never-written words read as zero
  assign window  = {(hi_ok && vld_hi_r) ? rd_hi_r : '0, vld_lo_r ? rd_lo_r : '0};
  assign win_sh  = window >> off;
  assign mask64  = {32'd0, emask} << off;
  assign ins64   = {32'd0, val_r & emask} << off;
  assign new_win = (window & ~mask64) | ins64;

  assign wr_lo = cmd.merge && (op_r == OP_WRITE) && !oor;
  assign we    = wr_lo || cmd.wr_hi;
  assign waddr = cmd.wr_hi ? addr_hi : addr_lo;
  assign wdata = cmd.wr_hi ? new_hi_r : new_win[31:0];

  assign sts.wr_hi_needed = (op_r == OP_WRITE) && !oor && hi_ok;
  assign sts.out_free     = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_data.opcode;
      val_r    <= in_data.write_value;
      w_r      <= elem_bits;
      bitpos_r <= BITPOS_W'(in_data.index) * BITPOS_W'(elem_bits);
    end
  end

  // memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_issue) begin
      rd_lo_r <= mem[addr_lo];
      rd_hi_r <= mem[addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_lo_r <= 1'b0;
      vld_hi_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (cmd.rd_issue) begin
        vld_lo_r <= vld_r[addr_lo];
        vld_hi_r <= vld_r[addr_hi];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      res_oor_r <= oor;
      res_rd_r  <= (!oor && op_r == OP_READ) ? READ_W'(win_sh[31:0] & emask) : '0;
      res_tr_r  <= !oor && (op_r == OP_WRITE) && (val_r > emask);
      new_hi_r  <= new_win[63:32];
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.push) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r.read_value   <= res_rd_r;
      out_data_r.truncated    <= res_tr_r;
      out_data_r.out_of_range <= res_oor_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/packed_bitfield_array_core.sv =====
// top level of the packed bitfield array: register port, sequencer and datapath
//
// A store of 64 words of 32 bits holds elements of element_bits width (0..31),
// packed end to end from bit 0 of word 0; an element may straddle two words.
// Input channel (in_valid / in_stall / in_data): one beat reads or writes one
// element by index. Result channel (out_valid / out_stall / out_data): exactly
// one beat per input beat, in order. A write keeps only the low element_bits
// bits, flagging truncated if any higher bit was set; an element past the end
// of the store is flagged out_of_range and the store is left alone.
// After the accepting edge a read step reads both words (two read ports), a
// merge step merges and, on a write, writes the low word, a further step
// writes the high word on a write that has one, and a push step loads the
// result register. The block takes no new beat until it is back in idle; the
// single write port is why the high word needs a step of its own. A beat can
// be accepted while the previous result still waits; a stalled receiver holds
// the sequencer in its final step until the result register frees up.
// Reset (rst_n, synchronous) clears the per-word valid bits, so the whole
// store reads as zero at once; element_bits returns to 8, written at address 0.
`timescale 1ns / 1ps
module packed_bitfield_array_core import pba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [EBITS_W-1:0] elem_bits_r, elem_bits_nxt;
  logic               cfg_wr;
  cmd_t               cmd;
  sts_t               sts;

  // register port: always ready, low address bits ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    elem_bits_nxt = elem_bits_r;
    if (cfg_wr && cfg_paddr[2] == REG_ELEM_BITS) begin
      elem_bits_nxt = cfg_pwdata[EBITS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_bits_r <= ELEM_BITS_RESET;
    end else begin
      elem_bits_r <= elem_bits_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ELEM_BITS) ?
                      CFG_DATA_W'(elem_bits_r) : '0;

  // sequencer
  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store and bit merge
  pba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .elem_bits (elem_bits_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one item at a time: an accepted beat blocks the next one
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // a loaded result is always presented
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_valid)
    else $error("result loaded but not valid");

  // at most one sequencer command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.rd_issue, cmd.merge, cmd.wr_hi, cmd.push}))
    else $error("overlapping sequencer commands");

endmodule

// ===== tb/pba_result_checker.sv =====
// result checker for the packed bitfield array: tracks the register, predicts each beat, compares
`timescale 1ns / 1ps
module pba_result_checker import pba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_t                  out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    errors,
  output int                    pending
);

  localparam logic [CFG_ADDR_W-1:0] ELEM_BITS_ADDR = CFG_ADDR_W'(REG_ELEM_BITS) << 2;

  logic [WORD_W-1:0]  packed_store [STORE_WORDS];
  logic [EBITS_W-1:0] elem_width;
  out_t               expected_results [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // reads or writes one element in the shadow store and returns the result beat
  function automatic out_t predict_access(in_t beat);
    logic [63:0] emask;
    logic [63:0] window;
    logic [63:0] span;
    logic [31:0] hi_word;
    int unsigned bitpos;
    int unsigned word_idx;
    int unsigned off;
    out_t        res;
    res    = '0;
    emask  = (64'd1 << elem_width) - 64'd1;
    bitpos = int'(beat.index) * int'(elem_width);
    if (bitpos + elem_width > TOTAL_BITS) begin
      res.out_of_range = 1'b1;
    end else if (elem_width != 0) begin
      word_idx = bitpos >> 5;
      off      = bitpos & 31;
      hi_word  = (word_idx + 1 < STORE_WORDS) ? packed_store[word_idx + 1] : '0;
      window   = {hi_word, packed_store[word_idx]};
      if (beat.opcode == OP_READ) begin
        res.read_value = READ_W'((window >> off) & emask);
      end else begin
        span          = emask << off;
        res.truncated = (64'(beat.write_value) > emask);
        window        = (window & ~span) | ((64'(beat.write_value) & emask) << off);
        packed_store[word_idx] = window[31:0];
        if (word_idx + 1 < STORE_WORDS) packed_store[word_idx + 1] = window[63:32];
      end
    end else if (beat.opcode == OP_WRITE && beat.write_value != 0) begin
      res.truncated = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (packed_store[i]) packed_store[i] = '0;
      elem_width = ELEM_BITS_RESET;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ELEM_BITS_ADDR)
        elem_width = cfg_pwdata[EBITS_W-1:0];
      if (in_valid && !in_stall)
        expected_results.push_back(predict_access(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none actual %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value expected %h actual %h", $time,
                     want.read_value, out_data.read_value);
          end
          if (out_data.truncated !== want.truncated) begin
            errors++;
            $display("%0t: truncated expected %b actual %b", $time,
                     want.truncated, out_data.truncated);
          end
          if (out_data.out_of_range !== want.out_of_range) begin
            errors++;
            $display("%0t: out_of_range expected %b actual %b", $time,
                     want.out_of_range, out_data.out_of_range);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/packed_bitfield_array_core_tb.sv =====
// testbench top for the packed bitfield array: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module packed_bitfield_array_core_tb;
  import pba_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ELEM_BITS_ADDR = CFG_ADDR_W'(REG_ELEM_BITS) << 2;
  // cycles to let pass once nothing is outstanding, covers the longest write path
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;
  // ~900 beats, each at its worst case, plus holds, many times over
  localparam int CYCLE_LIMIT   = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int errors;
  int pending;
  int cycle_count = 0;

  // receiver behaviour, set by the stimulus process
  int stall_pct  = 0;
  logic hold_phase = 1'b0;
  int hold_count = 0;

  packed_bitfield_array_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pba_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .errors      (errors),
    .pending     (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("packed_bitfield_array_core: mismatch");
      $finish;
    end
  end

  // receiver: random stall per cycle, or a long hold-off counted here
  // while the sender keeps offering beats so the block backs up
  always @(posedge clk) begin
    if (hold_phase && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      if (!hold_phase) hold_count <= 0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // APB write of element_bits: setup then access; upper data bits carry noise
  task automatic write_elem_bits(input logic [EBITS_W-1:0] bits);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ELEM_BITS_ADDR;
    cfg_pwdata  <= (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(32'h1F)) | CFG_DATA_W'(bits);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // offers one beat and returns just after the edge that took it;
  // valid is left high so back-to-back beats need no second assignment
  task automatic send_beat(input in_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic access(input logic op, input int idx, input logic [31:0] value);
    in_t beat;
    beat.opcode      = op;
    beat.index       = INDEX_W'(idx);
    beat.write_value = value;
    send_beat(beat);
  endtask

  // random sender gap, geometric in length
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // sender pauses until every result has come back, then lets the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly in-range indices, with a dense low window so reads find written data,
  // plus the edge of the store and the full index range
  function automatic in_t random_beat(input logic [EBITS_W-1:0] w);
    in_t         beat;
    int          capacity;
    int          pick;
    int          idx;
    logic [31:0] fit_mask;
    capacity = (w == 0) ? 2048 : TOTAL_BITS / w;
    if (capacity > 2048) capacity = 2048;
    fit_mask = (w == 0) ? 32'd0 : ((32'd1 << w) - 32'd1);
    pick = $urandom_range(99);
    if (pick < 45)      idx = $urandom_range(0, (capacity < 64 ? capacity : 64) - 1);
    else if (pick < 75) idx = $urandom_range(0, capacity - 1);
    else if (pick < 88) idx = capacity - 2 + $urandom_range(0, 3);
    else                idx = $urandom_range(0, 2047);
    if (idx < 0) idx = 0;
    if (idx > 2047) idx = 2047;
    beat.index  = INDEX_W'(idx);
    beat.opcode = $urandom_range(1) ? OP_WRITE : OP_READ;
    pick = $urandom_range(99);
    if (pick < 30)      beat.write_value = $urandom;
    else if (pick < 70) beat.write_value = $urandom & fit_mask;
    else if (pick < 80) beat.write_value = 32'd0;
    else if (pick < 90) beat.write_value = 32'hFFFF_FFFF;
    else                beat.write_value = fit_mask + ($urandom_range(1));
    return beat;
  endfunction

  initial begin
    logic [EBITS_W-1:0] widths [9];
    int                 send_pct;
    int                 beats;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset width of 8, cleared store, last element and one past it
    access(OP_READ,  0,    32'd0);
    access(OP_WRITE, 0,    32'hFFFF_FFFF);
    access(OP_READ,  0,    32'd0);
    access(OP_WRITE, 255,  32'h0000_00A5);
    access(OP_READ,  255,  32'd0);
    access(OP_READ,  256,  32'd0);
    access(OP_WRITE, 2047, 32'd1);
    drain();

    // widest elements straddle words, including the last word pair
    write_elem_bits(5'd31);
    access(OP_WRITE, 1,  32'h7FFF_FFFF);
    access(OP_READ,  1,  32'd0);
    access(OP_WRITE, 65, 32'h8000_0000);
    access(OP_READ,  65, 32'd0);
    access(OP_WRITE, 66, 32'd1);
    access(OP_READ,  0,  32'd0);
    drain();

    // single-bit elements: the very last bit of the store
    write_elem_bits(5'd1);
    access(OP_WRITE, 2047, 32'd1);
    access(OP_READ,  2047, 32'd0);
    access(OP_WRITE, 0,    32'd2);
    drain();

    // zero-width elements: nothing stored, nonzero writes flag truncation
    write_elem_bits(5'd0);
    access(OP_READ,  2047, 32'd0);
    access(OP_WRITE, 2047, 32'd5);
    access(OP_WRITE, 3,    32'd0);
    access(OP_READ,  0,    32'd0);
    drain();

    // random phases over several widths and the four idling patterns
    widths = '{5'd31, 5'd1, 5'd17, 5'd0, 5'd8, 5'd30, 5'd5, 5'd13,
               EBITS_W'($urandom_range(1, 31))};
    foreach (widths[p]) begin
      write_elem_bits(widths[p]);
      case (p % 4)
        0: begin send_pct = 0;  stall_pct <= 0;  end
        1: begin send_pct = 46; stall_pct <= 0;  end
        2: begin send_pct = 0;  stall_pct <= 46; end
        default: begin send_pct = 18; stall_pct <= 18; end
      endcase
      beats = (widths[p] == 0) ? 40 : 100;
      repeat (beats) begin
        sender_gap(send_pct);
        send_beat(random_beat(widths[p]));
      end

      // back-pressure: the receiver holds off while the sender keeps going
      if (p == 2) begin
        hold_phase <= 1'b1;
        repeat (40) send_beat(random_beat(widths[p]));
        in_valid   <= 1'b0;
        @(posedge clk);
        hold_phase <= 1'b0;
      end
      drain();
    end

    if (errors == 0)
      $display("packed_bitfield_array_core: match");
    else
      $display("packed_bitfield_array_core: mismatch");
    $finish;
  end

endmodule
